[design/esr_pkg.sv]
`timescale 1ns / 1ps
// shared constants, servo map, ease table and control structs of the servo pulse ramp
package esr_pkg;

  localparam int unsigned NUM_SERVOS = 7;
  localparam int unsigned EASE_DEPTH = 1024;
  localparam int unsigned FRAC_BITS  = 4;

  localparam int unsigned MAP_COUNT = 7;
  localparam int unsigned SERVO_CNT = (NUM_SERVOS < MAP_COUNT) ? NUM_SERVOS : MAP_COUNT;
  localparam int unsigned IDX_W     = (SERVO_CNT > 1) ? $clog2(SERVO_CNT) : 1;

  localparam int unsigned TMR_W   = 3;
  localparam int unsigned CH_W    = 3;
  localparam int unsigned ANGLE_W = 12;
  localparam int unsigned VAL_W   = 13;
  localparam int unsigned STEPS_W = 16;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned CMP_W   = 17;
  localparam int unsigned E_W     = 16;
  localparam int unsigned RANGE_W = 9;

  localparam int unsigned K_W    = $clog2(EASE_DEPTH);
  localparam int unsigned KCNT_W = $clog2(K_W);
  localparam int unsigned NUM_W  = POS_W + K_W;

  localparam int unsigned ANGLE_MAX  = 3600;
  localparam int unsigned RAMP_RESET = 20;

  localparam logic [2:0] ADDR_RAMP_STEPS = 3'd0;

  // goal = 500*2^F + floor(200*2^F*angle / range)
  localparam int unsigned GOAL_BASE = 500 << FRAC_BITS;
  localparam int unsigned SET_SCALE = 200 << FRAC_BITS;
  localparam int unsigned N_MAX     = SET_SCALE * ANGLE_MAX;
  localparam int unsigned N_W       = $clog2(N_MAX + 1);
  localparam int unsigned RCP_SH    = N_W;
  localparam int unsigned RCP_W     = N_W - 7;
  localparam int unsigned PROD_W    = N_W + RCP_W;
  localparam int unsigned REM_W     = RCP_W + RANGE_W;

  typedef enum logic {
    CMD_SET  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  localparam logic [TMR_W-1:0] MAP_TIMER [MAP_COUNT] = '{
    3'd1, 3'd1, 3'd1, 3'd1, 3'd3, 3'd3, 3'd4
  };
  localparam logic [CH_W-1:0] MAP_CHANNEL [MAP_COUNT] = '{
    3'd1, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4, 3'd3
  };
  localparam logic [RANGE_W-1:0] MAP_RANGE [MAP_COUNT] = '{
    9'd270, 9'd270, 9'd360, 9'd360, 9'd180, 9'd180, 9'd360
  };
  localparam logic [RCP_W-1:0] MAP_RECIP [MAP_COUNT] = '{
    RCP_W'((64'd1 << RCP_SH) / 270), RCP_W'((64'd1 << RCP_SH) / 270),
    RCP_W'((64'd1 << RCP_SH) / 360), RCP_W'((64'd1 << RCP_SH) / 360),
    RCP_W'((64'd1 << RCP_SH) / 180), RCP_W'((64'd1 << RCP_SH) / 180),
    RCP_W'((64'd1 << RCP_SH) / 360)
  };

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // (2n)(2n+1) denominators of the sine series
  localparam longint unsigned SERIES_DIV [1:12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  // sin^2(pi*k/(2*D)) in Q0.16 by a truncating integer series, evaluated at elaboration
  function automatic logic [E_W-1:0] ease_of(input longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned s;
    longint unsigned e;
    longint          sum;
    // 2*D is a power of two
    x = (PI_Q30 * k) >> (K_W + 1);
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / SERIES_DIV[n];
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    s = longint'(sum);
    e = (s * s + (64'd1 << 43)) >> 44;
    if (e > 64'd65535) begin
      e = 64'd65535;
    end
    return e[E_W-1:0];
  endfunction

  typedef logic [E_W-1:0] ease_rom_t [EASE_DEPTH];

  function automatic ease_rom_t build_ease_rom();
    ease_rom_t r;
    for (int i = 0; i < EASE_DEPTH; i++) begin
      r[i] = ease_of(64'(i));
    end
    return r;
  endfunction

  localparam ease_rom_t EASE_ROM = build_ease_rom();

  typedef struct packed {
    logic cap;       // capture input word
    logic set_calc;  // saturate angle, scale, look up servo
    logic set_mul;   // multiply by range reciprocal
    logic set_wr;    // correct quotient, write goal
    logic chk;       // test ramp position, start divider or complete
    logic div_step;  // one quotient bit
    logic rom_rd;    // read ease factor
    logic mul;       // blend products
    logic sum;       // add and scale
    logic emit;      // move result into output register
    logic idx_inc;   // next servo
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_tick;
    logic active;
    logic div_last;
    logic out_free;
    logic last_servo;
  } dpath_sts_t;

endpackage

[design/esr_ctrl.sv]
`timescale 1ns / 1ps
// sequencer of the servo pulse ramp: set and tick command flow
module esr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  esr_pkg::dpath_sts_t sts_i,
  output esr_pkg::ctrl_cmd_t  cmd_o
);
  import esr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SET_A,
    S_SET_B,
    S_SET_C,
    S_CHK,
    S_DIV,
    S_ROM,
    S_MUL,
    S_SUM,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = sts_i.in_tick ? S_CHK : S_SET_A;
        end
      end
      S_SET_A: begin
        cmd_o.set_calc = 1'b1;
        state_d        = S_SET_B;
      end
      S_SET_B: begin
        cmd_o.set_mul = 1'b1;
        state_d       = S_SET_C;
      end
      S_SET_C: begin
        cmd_o.set_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        state_d   = sts_i.active ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_ROM;
        end
      end
      S_ROM: begin
        cmd_o.rom_rd = 1'b1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_servo) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_CHK;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/esr_dpath.sv]
`timescale 1ns / 1ps
// datapath: per-servo state, goal scaling, bit-serial ease index divider, blend, output word
module esr_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_command_i,
  input  logic [esr_pkg::TMR_W-1:0]    in_timer_i,
  input  logic [esr_pkg::CH_W-1:0]     in_channel_i,
  input  logic [esr_pkg::ANGLE_W-1:0]  in_angle_i,
  input  logic [esr_pkg::STEPS_W-1:0]  ramp_steps_i,
  input  esr_pkg::ctrl_cmd_t           cmd_i,
  output esr_pkg::dpath_sts_t          sts_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [esr_pkg::TMR_W-1:0]    out_timer_o,
  output logic [esr_pkg::CH_W-1:0]     out_channel_o,
  output logic [esr_pkg::VAL_W-1:0]    out_value_o,
  output logic                         out_written_o,
  output logic                         out_last_o
);
  import esr_pkg::*;

  localparam int unsigned ACC_W = 2 * CMP_W + 1;

  // per-servo state
  logic [CMP_W-1:0] start_q [SERVO_CNT];
  logic [CMP_W-1:0] goal_q  [SERVO_CNT];
  logic [POS_W-1:0] pos_q   [SERVO_CNT];

  logic [IDX_W-1:0]   idx_q;
  logic [TMR_W-1:0]   tmr_q;
  logic [CH_W-1:0]    ch_q;
  logic [ANGLE_W-1:0] angle_q;

  // set path
  logic              hit_q;
  logic [N_W-1:0]    n_q;
  logic [PROD_W-1:0] prod_q;

  // tick path
  logic [POS_W-1:0]  rem_q;
  logic [K_W-1:0]    low_q;
  logic [K_W-1:0]    quo_q;
  logic [KCNT_W-1:0] cnt_q;
  logic [E_W-1:0]    ease_q;
  logic [2*CMP_W-1:0] pa_q;
  logic [2*CMP_W-1:0] pb_q;
  logic [VAL_W-1:0]  res_val_q;
  logic              res_wr_q;

  // output register
  logic              out_valid_q;
  logic [TMR_W-1:0]  out_timer_q;
  logic [CH_W-1:0]   out_channel_q;
  logic [VAL_W-1:0]  out_value_q;
  logic              out_written_q;
  logic              out_last_q;

  logic               hit_c;
  logic [IDX_W-1:0]   hit_idx_c;
  logic [ANGLE_W-1:0] a_sat_c;
  logic [N_W-1:0]     n_c;
  logic [RCP_W-1:0]   q0_c;
  logic [REM_W-1:0]   qd_c;
  logic [REM_W-1:0]   rem_c;
  logic [RCP_W-1:0]   q_c;
  logic [CMP_W-1:0]   goal_c;
  logic [POS_W-1:0]   pos_c;
  logic [NUM_W-1:0]   numer_c;
  logic [POS_W:0]     trial_c;
  logic               ge_c;
  logic [CMP_W-1:0]   one_minus_c;
  logic [ACC_W-1:0]   acc_c;
  logic               out_free_c;

  // servo lookup for a set
  always_comb begin
    hit_c     = 1'b0;
    hit_idx_c = '0;
    for (int i = 0; i < SERVO_CNT; i++) begin
      if (MAP_TIMER[i] == tmr_q && MAP_CHANNEL[i] == ch_q) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
    end
  end

  assign a_sat_c = (angle_q > ANGLE_W'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) : angle_q;
  assign n_c     = N_W'({{(N_W-ANGLE_W){1'b0}}, a_sat_c} * N_W'(SET_SCALE));

  // reciprocal estimate is at most one low, fix it with one compare
  assign q0_c   = prod_q[PROD_W-1:RCP_SH];
  assign qd_c   = REM_W'(q0_c) * REM_W'(MAP_RANGE[idx_q]);
  assign rem_c  = REM_W'(n_q) - qd_c;
  assign q_c    = (rem_c >= REM_W'(MAP_RANGE[idx_q])) ? RCP_W'(q0_c + 1'b1) : q0_c;
  assign goal_c = CMP_W'(GOAL_BASE) + CMP_W'(q_c);

  assign pos_c   = pos_q[idx_q];
  assign numer_c = NUM_W'(pos_c) * NUM_W'(EASE_DEPTH);

  // restoring division of pos*D by ramp_steps, one bit a cycle
  assign trial_c = {rem_q, low_q[K_W-1]};
  assign ge_c    = (trial_c >= {1'b0, ramp_steps_i});

  assign one_minus_c = CMP_W'(18'h10000 - {2'b00, ease_q});
  assign acc_c       = {1'b0, pa_q} + {1'b0, pb_q};

  assign out_free_c = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o            = '0;
    sts_o.in_tick    = (in_command_i == CMD_TICK);
    sts_o.active     = (pos_c < ramp_steps_i);
    sts_o.div_last   = (cnt_q == KCNT_W'(K_W - 1));
    sts_o.out_free   = out_free_c;
    sts_o.last_servo = (idx_q == IDX_W'(SERVO_CNT - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SERVO_CNT; i++) begin
        start_q[i] <= '0;
        goal_q[i]  <= '0;
        pos_q[i]   <= '0;
      end
      idx_q       <= '0;
      hit_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cap) begin
        idx_q <= '0;
      end
      if (cmd_i.set_calc) begin
        hit_q <= hit_c;
        idx_q <= hit_idx_c;
      end
      if (cmd_i.set_wr && hit_q) begin
        goal_q[idx_q] <= goal_c;
        pos_q[idx_q]  <= '0;
      end
      if (cmd_i.chk) begin
        cnt_q <= '0;
        if (!(pos_c < ramp_steps_i)) begin
          // move complete
          pos_q[idx_q]   <= '0;
          start_q[idx_q] <= goal_q[idx_q];
        end
      end
      if (cmd_i.div_step) begin
        cnt_q <= KCNT_W'(cnt_q + 1'b1);
      end
      if (cmd_i.sum) begin
        pos_q[idx_q] <= POS_W'(pos_c + 1'b1);
      end
      if (cmd_i.idx_inc) begin
        idx_q <= IDX_W'(idx_q + 1'b1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      tmr_q   <= in_timer_i;
      ch_q    <= in_channel_i;
      angle_q <= in_angle_i;
    end
    if (cmd_i.set_calc) begin
      n_q <= n_c;
    end
    if (cmd_i.set_mul) begin
      prod_q <= PROD_W'(n_q) * PROD_W'(MAP_RECIP[idx_q]);
    end
    if (cmd_i.chk) begin
      rem_q     <= numer_c[NUM_W-1:K_W];
      low_q     <= numer_c[K_W-1:0];
      quo_q     <= '0;
      res_val_q <= '0;
      res_wr_q  <= 1'b0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge_c ? POS_W'(trial_c - {1'b0, ramp_steps_i}) : POS_W'(trial_c);
      low_q <= {low_q[K_W-2:0], 1'b0};
      quo_q <= {quo_q[K_W-2:0], ge_c};
    end
    if (cmd_i.rom_rd) begin
      ease_q <= EASE_ROM[quo_q];
    end
    if (cmd_i.mul) begin
      pa_q <= (2*CMP_W)'(start_q[idx_q]) * (2*CMP_W)'(one_minus_c);
      pb_q <= (2*CMP_W)'(goal_q[idx_q]) * (2*CMP_W)'(ease_q);
    end
    if (cmd_i.sum) begin
      res_val_q <= VAL_W'(acc_c >> (16 + FRAC_BITS));
      res_wr_q  <= 1'b1;
    end
    if (cmd_i.emit) begin
      out_timer_q   <= MAP_TIMER[idx_q];
      out_channel_q <= MAP_CHANNEL[idx_q];
      out_value_q   <= res_val_q;
      out_written_q <= res_wr_q;
      out_last_q    <= (idx_q == IDX_W'(SERVO_CNT - 1));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_timer_o   = out_timer_q;
  assign out_channel_o = out_channel_q;
  assign out_value_o   = out_value_q;
  assign out_written_o = out_written_q;
  assign out_last_o    = out_last_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result word loaded over an untaken word");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < ramp_steps_i))
    else $error("divider remainder not below ramp length");

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rom_rd |-> (32'(quo_q) < EASE_DEPTH))
    else $error("ease index beyond table");

endmodule

[design/eased_servo_pulse_ramp.sv]
`timescale 1ns / 1ps
// top level of the eased servo pulse ramp: stream channels, register port, sequencer and datapath
//
// Input stream: one word is a set (tuser = 0) or a tick (tuser = 1). A set turns
// an angle into a compare goal for the addressed timer/channel and passes through
// states S_SET_A, S_SET_B and S_SET_C before s_axis_tready is high again; it emits nothing.
// A tick emits seven words, one per servo in the fixed order timer 1 ch 1..4,
// timer 3 ch 3..4, timer 4 ch 3; tlast marks the seventh, tuser is the written flag.
// A servo still ramping passes through the bit-serial divider that forms the ease
// index from position and ramp length; a servo whose move is complete skips it.
// The next word is accepted once the last result of the tick sits in the output
// register, even while that word waits to be taken. A stalled sink holds the
// output word and stops the sequencer at the next hand-off; nothing is dropped.
// Register 0 (byte address 0) is ramp_steps, 20 after reset; write it only while
// the block is idle. Reset clears all start, goal and position state to zero.
module eased_servo_pulse_ramp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // target_timer, target_channel, angle_tenths, zero pad
  input  logic [0:0]  s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // out_timer, out_channel, compare_value, zero pad
  output logic [0:0]  m_axis_tuser,  // written
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import esr_pkg::*;

  logic [STEPS_W-1:0] ramp_steps_q;
  ctrl_cmd_t          cmd;
  dpath_sts_t         sts;
  logic [TMR_W-1:0]   out_timer;
  logic [CH_W-1:0]    out_channel;
  logic [VAL_W-1:0]   out_value;
  logic               out_written;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_RAMP_STEPS) ? {{(32-STEPS_W){1'b0}}, ramp_steps_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_steps_q <= STEPS_W'(RAMP_RESET);
    end else if (psel && penable && pwrite && pready && paddr == ADDR_RAMP_STEPS) begin
      ramp_steps_q <= pwdata[STEPS_W-1:0];
    end
  end

  esr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  esr_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_command_i  (s_axis_tuser[0]),
    .in_timer_i    (s_axis_tdata[2:0]),
    .in_channel_i  (s_axis_tdata[5:3]),
    .in_angle_i    (s_axis_tdata[17:6]),
    .ramp_steps_i  (ramp_steps_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_timer_o   (out_timer),
    .out_channel_o (out_channel),
    .out_value_o   (out_value),
    .out_written_o (out_written),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, out_value, out_channel, out_timer};
  assign m_axis_tuser = out_written;

endmodule
